// ----- design/sorted_frame_priority_queue_unit_assert.svh -----
// Assertion macros used by the queue RTL.
`ifndef SORTED_FRAME_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_FRAME_PRIORITY_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTH

// prop must hold at every clock edge out of reset
`define SFPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cons must hold in the cycle after ante
`define SFPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define SFPQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- design/sfpq_pkg.sv -----
package sfpq_pkg;

	localparam int KEY_BITS       = 64;
	localparam int CFG_BITS       = 5;
	localparam int COUNT_OUT_BITS = 5;
	localparam int CAPACITY_RESET = 16;

	typedef enum logic [1:0] {
		MODE_PUSH     = 2'd0,
		MODE_POP      = 2'd1,
		MODE_POP_TYPE = 2'd2,
		MODE_RESERVED = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_READY = 2'd3
	} status_t;

	typedef enum logic {
		REG_CAPACITY       = 1'b0,
		REG_FILL_THRESHOLD = 1'b1
	} cfg_reg_t;

	// per-cell control for one queue operation
	typedef struct packed {
		logic push;   // insert new entry this cycle
		logic pop;    // shift toward head this cycle
		logic valid;  // cell holds a live entry
		logic tail;   // first empty cell
	} cell_ctl_t;

endpackage

// ----- design/sfpq_cell.sv -----
module sfpq_cell #(
	parameter int TYPE_BITS   = 4,
	parameter int HANDLE_BITS = 16
) (
	input  logic                          clk,
	input  sfpq_pkg::cell_ctl_t           ctl,
	input  logic [sfpq_pkg::KEY_BITS-1:0] new_key,
	input  logic [TYPE_BITS-1:0]          new_type,
	input  logic [HANDLE_BITS-1:0]        new_handle,
	input  logic                          prev_gt,
	input  logic [sfpq_pkg::KEY_BITS-1:0] prev_key,
	input  logic [TYPE_BITS-1:0]          prev_type,
	input  logic [HANDLE_BITS-1:0]        prev_handle,
	input  logic [sfpq_pkg::KEY_BITS-1:0] next_key,
	input  logic [TYPE_BITS-1:0]          next_type,
	input  logic [HANDLE_BITS-1:0]        next_handle,
	output logic                          gt,
	output logic [sfpq_pkg::KEY_BITS-1:0] cur_key,
	output logic [TYPE_BITS-1:0]          cur_type,
	output logic [HANDLE_BITS-1:0]        cur_handle
);
	import sfpq_pkg::*;

	logic [KEY_BITS-1:0]    key_q;
	logic [TYPE_BITS-1:0]   type_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic                   take_new;

	// keys are sorted, so gt is a run of ones from the insert point to the last live entry
	assign gt       = ctl.valid && (key_q > new_key);
	assign take_new = !prev_gt && (gt || ctl.tail);

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			key_q    <= next_key;
			type_q   <= next_type;
			handle_q <= next_handle;
		end else if (ctl.push) begin
			if (prev_gt) begin
				key_q    <= prev_key;
				type_q   <= prev_type;
				handle_q <= prev_handle;
			end else if (take_new) begin
				key_q    <= new_key;
				type_q   <= new_type;
				handle_q <= new_handle;
			end
		end
	end

	assign cur_key    = key_q;
	assign cur_type   = type_q;
	assign cur_handle = handle_q;

endmodule

// ----- design/sorted_frame_priority_queue_unit.sv -----
// Sorted priority queue of up to DEPTH frame entries, smallest 64-bit key at the
// head; equal keys leave in arrival order. Entries live in a row of cells, each
// comparing its key against the incoming one, so the row is updated in parallel:
// an accepted operation returns its result in the output register on the
// next cycle, and a new operation is taken every cycle the result is consumed.
// Throughput is set by the per-cell 64-bit compare feeding the shift of the row.
// Mode 0 pushes, mode 1 pops the head, mode 2 pops it only when the queue is not
// preparing and its frame type matches. Configuration (capacity, fill threshold)
// must be written via the cfg port only while the queue is idle; not enforced.
`include "sorted_frame_priority_queue_unit_assert.svh"

module sorted_frame_priority_queue_unit #(
	parameter int DEPTH       = 16,
	parameter int TYPE_BITS   = 4,
	parameter int HANDLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [sfpq_pkg::CFG_BITS-1:0]       cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          mode,
	input  logic [sfpq_pkg::KEY_BITS-1:0]       sort_key,
	input  logic [TYPE_BITS-1:0]                frame_type,
	input  logic [HANDLE_BITS-1:0]              payload_handle,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          status,
	output logic [HANDLE_BITS-1:0]              out_handle,
	output logic [sfpq_pkg::KEY_BITS-1:0]       out_key,
	output logic [TYPE_BITS-1:0]                out_type,
	output logic [sfpq_pkg::COUNT_OUT_BITS-1:0] fill_count,
	output logic                                preparing_flag
);
	import sfpq_pkg::*;

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > CFG_BITS) ? CW : CFG_BITS;

	logic [CFG_BITS-1:0] capacity_q;
	logic [CFG_BITS-1:0] thr_q;
	logic [CW-1:0]       count_q;
	logic                prep_q;

	logic                   out_valid_q;
	status_t                status_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [TYPE_BITS-1:0]   type_q;
	logic [CW-1:0]          count_out_q;
	logic                   prep_out_q;

	cell_ctl_t              ctl    [DEPTH];
	logic                   gt     [DEPTH];
	logic [KEY_BITS-1:0]    c_key  [DEPTH];
	logic [TYPE_BITS-1:0]   c_type [DEPTH];
	logic [HANDLE_BITS-1:0] c_hdl  [DEPTH];

	logic          in_fire;
	logic          push_ok;
	logic          pop_ok;
	status_t       status_d;
	logic [CW-1:0] count_d;
	logic          prep_d;
	logic [CMPW-1:0] cap_eff;
	logic          full;
	logic [CW-1:0] count_inc;
	logic [CW-1:0] count_dec;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CFG_BITS'(CAPACITY_RESET);
			thr_q      <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CAPACITY:       capacity_q <= cfg_data;
				REG_FILL_THRESHOLD: thr_q      <= cfg_data;
				default:            ;
			endcase
		end
	end

	assign cap_eff   = (CMPW'(capacity_q) > CMPW'(DEPTH)) ? CMPW'(DEPTH) : CMPW'(capacity_q);
	assign full      = CMPW'(count_q) >= cap_eff;
	assign count_inc = count_q + 1'b1;
	assign count_dec = count_q - 1'b1;

	always_comb begin
		push_ok  = 1'b0;
		pop_ok   = 1'b0;
		status_d = ST_OK;
		case (mode)
			MODE_PUSH: begin
				if (full) status_d = ST_FULL;
				else      push_ok  = 1'b1;
			end
			MODE_POP: begin
				if (count_q == '0) status_d = ST_EMPTY;
				else               pop_ok   = 1'b1;
			end
			MODE_POP_TYPE: begin
				if (count_q == '0)                        status_d = ST_EMPTY;
				else if (prep_q || c_type[0] != frame_type) status_d = ST_NOT_READY;
				else                                      pop_ok   = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		count_d = count_q;
		prep_d  = prep_q;
		if (push_ok) begin
			count_d = count_inc;
			if (CMPW'(count_inc) >= CMPW'(thr_q)) prep_d = 1'b0;
		end else if (pop_ok) begin
			count_d = count_dec;
			if (count_dec == '0) prep_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			prep_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				count_q     <= count_d;
				prep_q      <= prep_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			status_q    <= status_d;
			handle_q    <= pop_ok ? c_hdl[0]  : '0;
			key_q       <= pop_ok ? c_key[0]  : '0;
			type_q      <= pop_ok ? c_type[0] : '0;
			count_out_q <= count_d;
			prep_out_q  <= prep_d;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                   p_gt;
		logic [KEY_BITS-1:0]    p_key;
		logic [TYPE_BITS-1:0]   p_type;
		logic [HANDLE_BITS-1:0] p_hdl;
		logic [KEY_BITS-1:0]    n_key;
		logic [TYPE_BITS-1:0]   n_type;
		logic [HANDLE_BITS-1:0] n_hdl;

		assign ctl[i].push  = in_fire && push_ok;
		assign ctl[i].pop   = in_fire && pop_ok;
		assign ctl[i].valid = CW'(i) < count_q;
		assign ctl[i].tail  = CW'(i) == count_q;

		if (i == 0) begin : g_first
			assign p_gt   = 1'b0;
			assign p_key  = sort_key;
			assign p_type = frame_type;
			assign p_hdl  = payload_handle;
		end else begin : g_mid
			assign p_gt   = gt[i-1];
			assign p_key  = c_key[i-1];
			assign p_type = c_type[i-1];
			assign p_hdl  = c_hdl[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign n_key  = c_key[i];
			assign n_type = c_type[i];
			assign n_hdl  = c_hdl[i];
		end else begin : g_inner
			assign n_key  = c_key[i+1];
			assign n_type = c_type[i+1];
			assign n_hdl  = c_hdl[i+1];
		end

		sfpq_cell #(
			.TYPE_BITS   (TYPE_BITS),
			.HANDLE_BITS (HANDLE_BITS)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl[i]),
			.new_key     (sort_key),
			.new_type    (frame_type),
			.new_handle  (payload_handle),
			.prev_gt     (p_gt),
			.prev_key    (p_key),
			.prev_type   (p_type),
			.prev_handle (p_hdl),
			.next_key    (n_key),
			.next_type   (n_type),
			.next_handle (n_hdl),
			.gt          (gt[i]),
			.cur_key     (c_key[i]),
			.cur_type    (c_type[i]),
			.cur_handle  (c_hdl[i])
		);
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign out_handle     = handle_q;
	assign out_key        = key_q;
	assign out_type       = type_q;
	assign fill_count     = COUNT_OUT_BITS'(count_out_q);
	assign preparing_flag = prep_out_q;

	`SFPQ_ASSERT(a_count_range, clk, arst_n, count_q <= CW'(DEPTH), "count above depth")
	`SFPQ_ASSERT(a_empty_prep, clk, arst_n, (count_q != '0) || prep_q, "empty queue not preparing")
	`SFPQ_ASSERT_NEXT(a_push_count, clk, arst_n, in_fire && push_ok, count_q == $past(count_q) + 1'b1, "push did not grow count")
	`SFPQ_ASSERT_NEXT(a_pop_count, clk, arst_n, in_fire && pop_ok, count_q == $past(count_q) - 1'b1, "pop did not shrink count")
	`SFPQ_ASSERT(a_nopop_zero, clk, arst_n, !out_valid_q || status_q == ST_OK || (key_q == '0 && handle_q == '0), "failed op carries entry data")

endmodule
